// ===== hw/rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_SBS  = 3'd4;
  localparam logic [2:0] PH_SU   = 3'd5;
  localparam logic [2:0] PH_HEX2 = 3'd6;

  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_BADESC = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_BADSUR = 3'd4;
  localparam logic [2:0] ST_NOQUOT = 3'd5;
  localparam logic [2:0] ST_CTRL   = 3'd6;

  localparam int unsigned MAX_WORDS = 4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  hcnt;
    logic [15:0] acc;
    logic [9:0]  hsur;
  } state_t;

  typedef struct packed {
    logic [MAX_WORDS-1:0][7:0] bytes;
    logic [2:0]                count;
    logic [2:0]                status;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jsu_in_if.sv =====
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/jsu_out_if.sv =====
`default_nettype none
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/json_string_unescape.sv =====
// Streaming JSON string unescaper: bytes arrive on chars, the unescaped
// string leaves on result as UTF-8 words, and each string ends with one
// status word (complete or an error code, always with last set). Bytes
// outside a string are dropped until an opening quote. A byte lands in an
// input register, is decoded combinationally, and its 0 to 4 words are
// loaded into a result register that sends one word per clock while
// result is ready, and plain bytes then sustain one per clock. A byte
// that yields n words holds the following byte in the input register
// until its last word is sent; the one-word-per-clock drain sets the \u rate.
`default_nettype none
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  jsu_in_if.sink     chars,
  jsu_out_if.source  result
);

  logic                      ivalid;
  logic [7:0]                ibyte;
  state_t                    st;
  state_t                    st_next;
  res_t                      res;
  logic [MAX_WORDS-1:0][7:0] obuf;
  logic [2:0]                cnt;
  logic [2:0]                ostatus;
  logic                      consume;
  logic                      out_fire;

  jsu_step u_step (
    .ch  (ibyte),
    .cur (st),
    .nxt (st_next),
    .res (res)
  );

  assign out_fire = result.valid && result.ready;
  assign consume  = ivalid && ((cnt == 3'd0) || ((cnt == 3'd1) && result.ready));
  assign chars.ready = !ivalid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (chars.ready) begin
      ivalid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      ibyte <= chars.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.hcnt  <= 2'd0;
      st.acc   <= 16'h0000;
      st.hsur  <= 10'd0;
    end else if (consume) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (consume) begin
      cnt <= res.count;
    end else if (out_fire) begin
      cnt <= cnt - 3'd1;
    end
    if (consume) begin
      obuf    <= res.bytes;
      ostatus <= res.status;
    end else if (out_fire) begin
      obuf <= {8'h00, obuf[MAX_WORDS-1:1]};
    end
  end

  assign result.valid    = (cnt != 3'd0);
  assign result.out_byte = obuf[0];
  assign result.status   = ostatus;
  assign result.last     = (cnt == 3'd1);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result count out of range");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_DATA) |-> result.last)
    else $error("status word not last");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !consume) |=> (cnt == $past(cnt) - 3'd1))
    else $error("result count did not step down");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (ivalid && !consume) |=> (ivalid && $stable(ibyte)))
    else $error("pending input byte lost");

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_step.sv =====
`default_nettype none
module jsu_step
  import jsu_pkg::*;
(
  input  wire logic [7:0] ch,
  input  wire state_t     cur,
  output state_t          nxt,
  output res_t            res
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic res_t one_word(input logic [7:0] b, input logic [2:0] s);
    res_t r;
    r          = '0;
    r.bytes[0] = b;
    r.count    = 3'd1;
    r.status   = s;
    return r;
  endfunction

  function automatic res_t encode(input logic [20:0] cp);
    res_t r;
    r        = '0;
    r.status = ST_DATA;
    if (cp <= 21'h00007F) begin
      r.bytes[0] = cp[7:0];
      r.count    = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.count    = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.count    = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.count    = 3'd4;
    end
    return r;
  endfunction

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_val = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {cur.acc[11:0], hex_val};
  assign pair_cp = 21'h010000 + {1'b0, cur.hsur, acc_new[9:0]};

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_BODY: begin
        if (ch == CH_QUOTE) begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_DONE);
        end else if (ch == CH_BSLASH) begin
          nxt.phase = PH_ESC;
        end else if (ch == 8'h00) begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_NOQUOT);
        end else if (ch < CH_SPACE) begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_CTRL);
        end else begin
          res = one_word(ch, ST_DATA);
        end
      end
      PH_ESC: begin
        nxt.phase = PH_BODY;
        unique case (ch)
          CH_QUOTE:  res = one_word(CH_QUOTE, ST_DATA);
          CH_BSLASH: res = one_word(CH_BSLASH, ST_DATA);
          CH_SLASH:  res = one_word(CH_SLASH, ST_DATA);
          CH_LB:     res = one_word(8'h08, ST_DATA);
          CH_LF:     res = one_word(8'h0C, ST_DATA);
          CH_LN:     res = one_word(8'h0A, ST_DATA);
          CH_LR:     res = one_word(8'h0D, ST_DATA);
          CH_LT:     res = one_word(8'h09, ST_DATA);
          CH_LU: begin
            nxt.phase = PH_HEX;
            nxt.hcnt  = 2'd0;
            nxt.acc   = 16'h0000;
          end
          default: begin
            nxt.phase = PH_IDLE;
            res       = one_word(8'h00, ST_BADESC);
          end
        endcase
      end
      PH_HEX, PH_HEX2: begin
        if (!hex_ok) begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_BADHEX);
        end else begin
          nxt.acc = acc_new;
          if (cur.hcnt != 2'd3) begin
            nxt.hcnt = cur.hcnt + 2'd1;
          end else begin
            nxt.hcnt = 2'd0;
            if (cur.phase == PH_HEX) begin
              if (acc_new[15:10] == 6'b110110) begin
                nxt.hsur  = acc_new[9:0];
                nxt.phase = PH_SBS;
              end else begin
                nxt.phase = PH_BODY;
                res       = encode({5'd0, acc_new});
              end
            end else if (acc_new[15:10] != 6'b110111) begin
              nxt.phase = PH_IDLE;
              res       = one_word(8'h00, ST_BADSUR);
            end else begin
              nxt.phase = PH_BODY;
              res       = encode(pair_cp);
            end
          end
        end
      end
      PH_SBS: begin
        if (ch == CH_BSLASH) begin
          nxt.phase = PH_SU;
        end else begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_BADSUR);
        end
      end
      PH_SU: begin
        if (ch == CH_LU) begin
          nxt.phase = PH_HEX2;
          nxt.hcnt  = 2'd0;
          nxt.acc   = 16'h0000;
        end else begin
          nxt.phase = PH_IDLE;
          res       = one_word(8'h00, ST_BADSUR);
        end
      end
      default: begin
        nxt.phase = (ch == CH_QUOTE) ? PH_BODY : PH_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
